/* rtl/ocu_pkg.sv */
// ----------------------------------------------------------------------------
// ocu_pkg
// Shared types, constants and helpers for the orbit camera update block.
// ----------------------------------------------------------------------------
package ocu_pkg;

	localparam logic signed [17:0] DEG90  = 18'sd11520;
	localparam logic signed [17:0] DEG180 = 18'sd23040;
	localparam logic signed [17:0] DEG360 = 18'sd46080;

	localparam logic [4:0]         CORDIC_LAST = 5'd17;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic [15:0]        RADIUS_RST  = 16'd2560;
	localparam logic [2:0]         MUL_OPS     = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ROT,
		ST_FIX,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_PY,
		OP_CXZ,
		OP_UX,
		OP_UZ,
		OP_PX,
		OP_PZ
	} mul_op_t;

	// arctan(2^-i) in 2^-15 degree
	function automatic logic signed [23:0] atan_lut(input logic [4:0] i);
		logic signed [23:0] v;
		unique case (i)
			5'd0:  v = 24'sd1474560;
			5'd1:  v = 24'sd870484;
			5'd2:  v = 24'sd459940;
			5'd3:  v = 24'sd233473;
			5'd4:  v = 24'sd117189;
			5'd5:  v = 24'sd58652;
			5'd6:  v = 24'sd29333;
			5'd7:  v = 24'sd14667;
			5'd8:  v = 24'sd7334;
			5'd9:  v = 24'sd3667;
			5'd10: v = 24'sd1833;
			5'd11: v = 24'sd917;
			5'd12: v = 24'sd458;
			5'd13: v = 24'sd229;
			5'd14: v = 24'sd115;
			5'd15: v = 24'sd57;
			5'd16: v = 24'sd29;
			5'd17: v = 24'sd14;
			default: v = 24'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [16:0] sat_pos(input logic signed [63:0] v);
		logic signed [16:0] r;
		if (v > 64'sd65535)
			r = 17'sd65535;
		else if (v < -64'sd65535)
			r = -17'sd65535;
		else
			r = v[16:0];
		return r;
	endfunction

	function automatic logic signed [15:0] sat_up(input logic signed [63:0] v);
		logic signed [15:0] r;
		if (v > 64'sd16384)
			r = 16'sd16384;
		else if (v < -64'sd16384)
			r = -16'sd16384;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

/* rtl/orbit_camera_update.sv */
// ----------------------------------------------------------------------------
// orbit_camera_update
// Orbit camera: angle update, CORDIC sine/cosine, position and up vector.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries elevation and azimuth steps in
// 1/128 degree. Elevation is clamped to +/-90 degrees, azimuth is wrapped
// once by 360. Output channel (out_valid/out_ready) returns the camera
// position (8 fractional bits) and up vector (Q1.14), one item per input.
// cfg_we/cfg_wdata write the orbit radius; write only while idle.
//
// An accepted input passes through the fold state, 18 CORDIC iterations
// (elevation and azimuth lanes share the counter and arctan table), the
// sign-fix state, the products on the shared 32x32 multiplier with its
// rounding stage, and the output load. A new item is taken only after the
// last one has left the sequencer; in_ready is high only while it is idle.
// A new item is accepted while the previous result still waits in the
// output register; if the receiver stalls, the finished result holds
// in the sequencer until the output register frees.
// Reset clears angles to zero, radius to 10.0, and drops out_valid.
// ----------------------------------------------------------------------------
module orbit_camera_update
	import ocu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [16:0] elevation_step,
	input  logic signed [16:0] azimuth_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic signed [15:0] up_x,
	output logic signed [15:0] up_y,
	output logic signed [15:0] up_z
);

	state_t st_q, st_d;

	logic [15:0]        radius_q;
	logic signed [14:0] elev_q;
	logic [16:0]        azim_q;

	logic signed [31:0] x_q [2];
	logic signed [31:0] y_q [2];
	logic signed [23:0] z_q [2];
	logic               neg_q [2];
	logic [4:0]         iter_q;

	logic signed [31:0] se_q, ce_q, nse_q, sa_q, ca_q, cxz_q;
	logic [2:0]         mcnt_q;
	mul_op_t            op_s1;
	logic signed [63:0] mul_p_s1;

	logic signed [16:0] px_q, py_q, pz_q;
	logic signed [15:0] ux_q, uy_q, uz_q;
	logic               out_valid_q;

	logic in_acc, out_load;

	// angle update
	logic signed [17:0] elev_sum, elev_nx, as_sat, az_sum, az_nx;

	always_comb begin
		elev_sum = $signed({{3{elev_q[14]}}, elev_q}) + $signed({elevation_step[16], elevation_step});
		if (elev_sum > DEG90)
			elev_nx = DEG90;
		else if (elev_sum < -DEG90)
			elev_nx = -DEG90;
		else
			elev_nx = elev_sum;
		if ($signed({azimuth_step[16], azimuth_step}) > DEG360)
			as_sat = DEG360;
		else if ($signed({azimuth_step[16], azimuth_step}) < -DEG360)
			as_sat = -DEG360;
		else
			as_sat = $signed({azimuth_step[16], azimuth_step});
		az_sum = $signed({1'b0, azim_q}) + as_sat;
		if (az_sum > DEG360)
			az_nx = az_sum - DEG360;
		else if (az_sum < 18'sd0)
			az_nx = az_sum + DEG360;
		else
			az_nx = az_sum;
	end

	// quadrant fold for both lanes
	logic signed [17:0] t_in [2];
	logic signed [17:0] t_a [2];
	logic signed [17:0] t_f [2];
	logic               f_neg [2];

	always_comb begin
		t_in[0] = $signed({{3{elev_q[14]}}, elev_q});
		t_in[1] = $signed({1'b0, azim_q});
		for (int l = 0; l < 2; l++) begin
			t_a[l] = (t_in[l] > DEG180) ? t_in[l] - DEG360 : t_in[l];
			if (t_a[l] > DEG90) begin
				t_f[l]  = t_a[l] - DEG180;
				f_neg[l] = 1'b1;
			end else if (t_a[l] < -DEG90) begin
				t_f[l]  = t_a[l] + DEG180;
				f_neg[l] = 1'b1;
			end else begin
				t_f[l]  = t_a[l];
				f_neg[l] = 1'b0;
			end
		end
	end

	// CORDIC rotation step, one per lane
	logic signed [31:0] x_nx [2];
	logic signed [31:0] y_nx [2];
	logic signed [23:0] z_nx [2];
	logic signed [23:0] atan_v;

	always_comb begin
		atan_v = atan_lut(iter_q);
		for (int l = 0; l < 2; l++) begin
			if (!z_q[l][23]) begin
				x_nx[l] = x_q[l] - (y_q[l] >>> iter_q);
				y_nx[l] = y_q[l] + (x_q[l] >>> iter_q);
				z_nx[l] = z_q[l] - atan_v;
			end else begin
				x_nx[l] = x_q[l] + (y_q[l] >>> iter_q);
				y_nx[l] = y_q[l] - (x_q[l] >>> iter_q);
				z_nx[l] = z_q[l] + atan_v;
			end
		end
	end

	// shared multiplier operands
	mul_op_t            op_issue;
	logic signed [31:0] mul_a, mul_b;

	always_comb begin
		op_issue = mul_op_t'(mcnt_q);
		unique case (op_issue)
			OP_PY:  begin mul_a = $signed({16'd0, radius_q}); mul_b = se_q; end
			OP_CXZ: begin mul_a = $signed({16'd0, radius_q}); mul_b = ce_q; end
			OP_UX:  begin mul_a = nse_q; mul_b = sa_q; end
			OP_UZ:  begin mul_a = nse_q; mul_b = ca_q; end
			OP_PX:  begin mul_a = cxz_q; mul_b = sa_q; end
			OP_PZ:  begin mul_a = cxz_q; mul_b = ca_q; end
			default: begin mul_a = 32'sd0; mul_b = 32'sd0; end
		endcase
	end

	// round half up and shift
	logic [5:0]         rnd_sh;
	logic signed [63:0] rnd_sum, rnd_v;
	logic signed [32:0] uy_sum;

	always_comb begin
		unique case (op_s1)
			OP_PY:  rnd_sh = 6'd30;
			OP_CXZ: rnd_sh = 6'd16;
			OP_UX:  rnd_sh = 6'd46;
			OP_UZ:  rnd_sh = 6'd46;
			OP_PX:  rnd_sh = 6'd44;
			OP_PZ:  rnd_sh = 6'd44;
			default: rnd_sh = 6'd16;
		endcase
		rnd_sum = mul_p_s1 + (64'sd1 <<< (rnd_sh - 6'd1));
		rnd_v   = rnd_sum >>> rnd_sh;
		uy_sum  = $signed({ce_q[31], ce_q}) + 33'sd32768;
	end

	// sequencer
	always_comb begin
		st_d     = st_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					st_d = ST_PREP;
			end
			ST_PREP: st_d = ST_ROT;
			ST_ROT: begin
				if (iter_q == CORDIC_LAST)
					st_d = ST_FIX;
			end
			ST_FIX: st_d = ST_MUL;
			ST_MUL: begin
				if (mcnt_q == MUL_OPS)
					st_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign in_acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= RADIUS_RST;
			elev_q      <= 15'sd0;
			azim_q      <= 17'd0;
			iter_q      <= 5'd0;
			mcnt_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				radius_q <= cfg_wdata;
			if (in_acc) begin
				elev_q <= elev_nx[14:0];
				azim_q <= az_nx[16:0];
			end
			if (st_q == ST_PREP)
				iter_q <= 5'd0;
			else if (st_q == ST_ROT)
				iter_q <= iter_q + 5'd1;
			if (st_q == ST_FIX)
				mcnt_q <= 3'd0;
			else if (st_q == ST_MUL)
				mcnt_q <= mcnt_q + 3'd1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_PREP) begin
			for (int l = 0; l < 2; l++) begin
				x_q[l]   <= CORDIC_GAIN;
				y_q[l]   <= 32'sd0;
				z_q[l]   <= $signed({t_f[l][15:0], 8'd0});
				neg_q[l] <= f_neg[l];
			end
		end else if (st_q == ST_ROT) begin
			for (int l = 0; l < 2; l++) begin
				x_q[l] <= x_nx[l];
				y_q[l] <= y_nx[l];
				z_q[l] <= z_nx[l];
			end
		end
		if (st_q == ST_FIX) begin
			se_q  <= neg_q[0] ? -y_q[0] : y_q[0];
			nse_q <= neg_q[0] ? y_q[0] : -y_q[0];
			ce_q  <= neg_q[0] ? -x_q[0] : x_q[0];
			sa_q  <= neg_q[1] ? -y_q[1] : y_q[1];
			ca_q  <= neg_q[1] ? -x_q[1] : x_q[1];
		end
		if (st_q == ST_MUL) begin
			if (mcnt_q < MUL_OPS) begin
				mul_p_s1 <= mul_a * mul_b;
				op_s1    <= op_issue;
			end
			if (mcnt_q == 3'd0)
				uy_q <= sat_up(64'(uy_sum >>> 16));
			else begin
				unique case (op_s1)
					OP_PY:  py_q  <= sat_pos(rnd_v);
					OP_CXZ: cxz_q <= rnd_v[31:0];
					OP_UX:  ux_q  <= sat_up(rnd_v);
					OP_UZ:  uz_q  <= sat_up(rnd_v);
					OP_PX:  px_q  <= sat_pos(rnd_v);
					OP_PZ:  pz_q  <= sat_pos(rnd_v);
					default: ;
				endcase
			end
		end
		if (out_load) begin
			pos_x <= px_q;
			pos_y <= py_q;
			pos_z <= pz_q;
			up_x  <= ux_q;
			up_y  <= uy_q;
			up_z  <= uz_q;
		end
	end

	assign out_valid = out_valid_q;

	elev_range_a: assert property (@(posedge clk) disable iff (!arst_n)
		elev_q <= 15'sd11520 && elev_q >= -15'sd11520)
		else $error("elevation out of range");

	azim_range_a: assert property (@(posedge clk) disable iff (!arst_n)
		azim_q <= 17'd46080)
		else $error("azimuth out of range");

	out_src_a: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == ST_OUT))
		else $error("result raised outside output load");

	accept_seq_a: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> st_q == ST_PREP)
		else $error("accepted item did not start sequence");

	rot_len_a: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_FIX |-> $past(iter_q) == CORDIC_LAST)
		else $error("CORDIC iteration count wrong");

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Orbit camera update testbench
// Drives elevation and azimuth steps through the valid/ready input, with
// random bursts and gaps, and stalls the output on a pattern of its own.
// A scoreboard keeps its own angle state and radius, runs its own CORDIC for
// each accepted item and compares every result field in order. The radius
// is rewritten between phases, zero and full scale among the settings.
// ----------------------------------------------------------------------------
package pose_check_pkg;

	localparam int QUARTER      = 11520;
	localparam int HALF         = 23040;
	localparam int TURN         = 46080;
	localparam int CORDIC_STEPS = 18;
	localparam longint CORDIC_K = 652032874;
	localparam longint POS_LIM  = 65535;
	localparam longint UP_LIM   = 16384;
	localparam logic [15:0] RADIUS_RESET = 16'd2560;

	// arctan(2^-i), 2^-15 degree
	localparam longint ATAN_TAB [CORDIC_STEPS] = '{
		1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667, 7334,
		3667, 1833, 917, 458, 229, 115, 57, 29, 14
	};

	typedef struct packed {
		logic signed [16:0] px;
		logic signed [16:0] py;
		logic signed [16:0] pz;
		logic signed [15:0] ux;
		logic signed [15:0] uy;
		logic signed [15:0] uz;
	} pose_t;

	class pose_scoreboard;
		pose_t       pending_poses[$];
		int          elev;
		int          azim;
		logic [15:0] radius;
		int          fails;
		int          checked;
		int          steps_seen;

		function new();
			elev       = 0;
			azim       = 0;
			radius     = RADIUS_RESET;
			fails      = 0;
			checked    = 0;
			steps_seen = 0;
		endfunction

		function void set_radius(logic [15:0] r);
			radius = r;
		endfunction

		function longint rnd_shr(longint v, int s);
			return (v + (64'sd1 <<< (s - 1))) >>> s;
		endfunction

		function longint clip(longint v, longint lim);
			if (v > lim)
				return lim;
			if (v < -lim)
				return -lim;
			return v;
		endfunction

		// angle in 1/128 degree; sine and cosine in Q30
		function void sin_cos(int t_in, output longint s, output longint c);
			int     t;
			bit     neg;
			longint x, y, z, xs, ys;
			t = t_in;
			neg = 1'b0;
			if (t > HALF)
				t -= TURN;
			if (t > QUARTER) begin
				t -= HALF;
				neg = 1'b1;
			end else if (t < -QUARTER) begin
				t += HALF;
				neg = 1'b1;
			end
			x = CORDIC_K;
			y = 0;
			z = longint'(t) * 256;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x -= ys;
					y += xs;
					z -= ATAN_TAB[i];
				end else begin
					x += ys;
					y -= xs;
					z += ATAN_TAB[i];
				end
			end
			s = neg ? -y : y;
			c = neg ? -x : x;
		endfunction

		function pose_t predict_pose(logic signed [16:0] es_in, logic signed [16:0] az_in);
			int     e, a, az;
			longint se, ce, sa, ca, r, cxz;
			pose_t  p;
			e = elev + int'(es_in);
			if (e > QUARTER)
				e = QUARTER;
			if (e < -QUARTER)
				e = -QUARTER;
			elev = e;
			az = int'(az_in);
			if (az > TURN)
				az = TURN;
			if (az < -TURN)
				az = -TURN;
			a = azim + az;
			if (a > TURN)
				a -= TURN;
			else if (a < 0)
				a += TURN;
			azim = a;
			sin_cos(e, se, ce);
			sin_cos(a, sa, ca);
			r = longint'(radius);
			cxz = rnd_shr(r * ce, 16);
			p.py = 17'(clip(rnd_shr(r * se, 30), POS_LIM));
			p.px = 17'(clip(rnd_shr(cxz * sa, 44), POS_LIM));
			p.pz = 17'(clip(rnd_shr(cxz * ca, 44), POS_LIM));
			p.uy = 16'(clip(rnd_shr(ce, 16), UP_LIM));
			p.ux = 16'(clip(rnd_shr(-(se * sa), 46), UP_LIM));
			p.uz = 16'(clip(rnd_shr(-(se * ca), 46), UP_LIM));
			return p;
		endfunction

		function void note_step(logic signed [16:0] es, logic signed [16:0] az);
			pending_poses.push_back(predict_pose(es, az));
			steps_seen++;
		endfunction

		function void cmp(string field, longint want, longint got);
			if (want != got) begin
				$error("%s expected %0d got %0d", field, want, got);
				fails++;
			end
		endfunction

		function void check_pose(pose_t got);
			pose_t want;
			if (pending_poses.size() == 0) begin
				$error("unexpected result, pos_x %0d pos_y %0d", got.px, got.py);
				fails++;
				return;
			end
			want = pending_poses.pop_front();
			checked++;
			cmp("pos_x", want.px, got.px);
			cmp("pos_y", want.py, got.py);
			cmp("pos_z", want.pz, got.pz);
			cmp("up_x", want.ux, got.ux);
			cmp("up_y", want.uy, got.uy);
			cmp("up_z", want.uz, got.uz);
		endfunction
	endclass

endpackage

module tb;
	import pose_check_pkg::*;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [15:0]        cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [16:0] elevation_step = '0;
	logic signed [16:0] azimuth_step = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [16:0] pos_x, pos_y, pos_z;
	logic signed [15:0] up_x, up_y, up_z;

	pose_t          seen_pose;
	pose_scoreboard board;
	int             radius_writes = 0;
	logic [11:0]    ready_cnt = '0;

	// directed steps; azimuth walks through quadrant edges and the wrap cases
	int dir_el [20] = '{0, 11520, 1, -23040, -1, 5760, 5760, 0, 0, 65535,
		-65536, 11520, -11520, 11519, 2, -46080, 46080, -5, -65536, 12345};
	int dir_az [20] = '{0, 11520, 11520, 11520, 11520, 11520, -11520, -1, 2, 65535,
		-65536, 46079, -46080, 3, 22, 46080, -46080, 17, 65535, -777};

	orbit_camera_update u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.elevation_step (elevation_step),
		.azimuth_step   (azimuth_step),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.up_x           (up_x),
		.up_y           (up_y),
		.up_z           (up_z)
	);

	assign seen_pose = {pos_x, pos_y, pos_z, up_x, up_y, up_z};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: always ready, coin flip, long stalls, mostly stalled
	always @(posedge clk) begin
		ready_cnt <= ready_cnt + 12'd1;
		case (ready_cnt[9:8])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= ($urandom_range(0, 1) == 0);
			2'd2: out_ready <= (ready_cnt[5:0] >= 6'd40);
			default: out_ready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_pose(seen_pose);
	end

	function automatic logic signed [16:0] pick_step();
		int sel;
		int v;
		int edges [9] = '{0, 1, -1, 11520, -11520, 23040, -23040, 46080, -46080};
		sel = $urandom_range(0, 99);
		if (sel < 40)
			v = int'($urandom_range(0, 2048)) - 1024;
		else if (sel < 70)
			v = int'($urandom_range(0, 92160)) - 46080;
		else if (sel < 85)
			v = $urandom;
		else
			v = edges[$urandom_range(0, 8)];
		return 17'(v);
	endfunction

	task automatic send_step(input logic signed [16:0] es, input logic signed [16:0] az);
		elevation_step <= es;
		azimuth_step   <= az;
		in_valid       <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_step(es, az);
	endtask

	task automatic pause(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_poses();
		pause(2);
		while (board.pending_poses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_radius(input logic [15:0] r);
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we    <= 1'b0;
		board.set_radius(r);
		radius_writes++;
	endtask

	initial begin
		int          sent;
		int          len;
		logic [15:0] radii [7];
		board = new();
		radii = '{16'd0, 16'd1, 16'd2560, 16'd256, 16'hFFFF, 16'd0, 16'd0};
		radii[5] = 16'($urandom);
		radii[6] = 16'($urandom_range(0, 4095));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_radius(16'hFFFF);
		for (int k = 0; k < 20; k++) begin
			send_step(17'(dir_el[k]), 17'(dir_az[k]));
			if (k % 5 == 4)
				pause(7);
		end
		drain_poses();
		foreach (radii[p]) begin
			write_radius(radii[p]);
			sent = 0;
			while (sent < 55) begin
				len = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(1, 12);
				repeat (len) send_step(pick_step(), pick_step());
				sent += len;
				if ($urandom_range(0, 15) == 0)
					drain_poses();
				else
					pause($urandom_range(1, 36));
			end
			drain_poses();
		end
		repeat (40) @(posedge clk);
		$display("Ran %0d camera updates over %0d radius settings, %0d results checked.",
			board.steps_seen, radius_writes, board.checked);
		if (board.fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
rtl/ocu_pkg.sv
rtl/orbit_camera_update.sv
verif/tb.sv
